// ===== src/pha_pkg.sv =====
// Shared types, constants and the tangent step table for the pixel heading unit.
// No dependencies.
package pha_pkg;

	localparam int CFG_W = 48;
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_Y_CUBIC  = 3'd0,
		REG_Y_SQUARE = 3'd1,
		REG_Y_LINEAR = 3'd2,
		REG_Y_CONST  = 3'd3,
		REG_X_SLOPE  = 3'd4,
		REG_X_OFFSET = 3'd5
	} cfg_reg_t;

	localparam logic signed [CFG_W-1:0] X_OFFSET_RST = 48'sd65536;

	localparam int COEF_STEP = 12;
	localparam int OFF_SHIFT = 12;
	localparam int LHS_SHIFT = 112;
	localparam int MUL_CHUNK = 8;
	localparam int TAN_W     = 38;
	localparam int NUM_STEPS = 89;
	localparam int ANG_W     = 8;
	localparam int CNT_W     = 7;

	localparam logic signed [ANG_W-1:0] HDG_MAX = 8'sd90;

	localparam logic [63:0] COS1_Q31 = 64'd2147156576;
	localparam logic [63:0] SIN1_Q31 = 64'd37478757;

	typedef struct packed {
		logic no_tgt;
		logic q_zero;
		logic sat90;
		logic neg;
	} pha_flags_t;

	// tan(k deg) with 32 fraction bits, by repeated Q1.31 one-degree rotation
	function automatic logic [TAN_W-1:0] tan_q32(input int k);
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] nc;
		logic [63:0] ns;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] t;
		c = 64'd1 << 31;
		s = 64'd0;
		for (int i = 1; i <= k; i++) begin
			nc = (c * COS1_Q31 - s * SIN1_Q31 + (64'd1 << 30)) >> 31;
			ns = (s * COS1_Q31 + c * SIN1_Q31 + (64'd1 << 30)) >> 31;
			c = nc;
			s = ns;
		end
		// sin * 2^32 / cos by shift and subtract
		num = s << 32;
		rem = '0;
		t = '0;
		for (int bi = 63; bi >= 0; bi--) begin
			rem = {rem[62:0], num[bi]};
			if (rem >= c) begin
				rem = rem - c;
				t[bi] = 1'b1;
			end
		end
		return t[TAN_W-1:0];
	endfunction

endpackage

// ===== src/pha_mul.sv =====
// Pipelined unsigned multiplier: one CW-bit slice of b per stage, with a side tag.
// No package dependencies; needs at least two slices.
module pha_mul #(
	parameter int WA = 48,
	parameter int WB = 42,
	parameter int CW = 14,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [WA-1:0] a,
	input  logic [WB-1:0] b,
	input  logic [TW-1:0] in_tag,
	output logic          out_vld,
	output logic [WA+WB-1:0] prod,
	output logic [TW-1:0] out_tag
);
	localparam int NC  = (WB + CW - 1) / CW;
	localparam int WBP = NC * CW;
	localparam int WP  = WA + WB;

	logic [WBP-1:0] b_ext;
	logic [NC-1:0]  vld_s;
	logic [WP-1:0]  acc_s [NC];
	logic [TW-1:0]  tag_s [NC];
	logic [WA-1:0]  a_s   [NC-1];
	logic [WBP-1:0] b_s   [NC-1];

	assign b_ext = WBP'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NC-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= WP'(a) * WP'(b_ext[CW-1:0]);
			tag_s[0] <= in_tag;
			a_s[0]   <= a;
			b_s[0]   <= b_ext;
			for (int i = 1; i < NC; i++) begin
				acc_s[i] <= acc_s[i-1]
					+ ((WP'(a_s[i-1]) * WP'(b_s[i-1][i*CW +: CW])) << (i * CW));
				tag_s[i] <= tag_s[i-1];
			end
			for (int i = 1; i < NC - 1; i++) begin
				a_s[i] <= a_s[i-1];
				b_s[i] <= b_s[i-1];
			end
		end
	end

	assign out_vld = vld_s[NC-1];
	assign prod    = acc_s[NC-1];
	assign out_tag = tag_s[NC-1];

endmodule

// ===== src/pha_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, quotient saturates to all ones.
// No package dependencies.
module pha_div #(
	parameter int WN = 125,
	parameter int WD = 156,
	parameter int QW = 38,
	parameter int TW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [WN-1:0] num,
	input  logic [WD-1:0] den,
	input  logic [TW-1:0] in_tag,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] out_tag
);
	localparam int WE = WD + QW;
	localparam int NS = QW + 1;

	logic [NS-1:0] vld_s;
	logic [NS-1:0] sat_s;
	logic [QW-1:0] quo_s [NS];
	logic [TW-1:0] tag_s [NS];
	logic [WN-1:0] rem_s [QW];
	logic [WD-1:0] den_s [QW];
	logic [WE-1:0] shf   [QW];
	logic [QW-1:0] fit;

	always_comb begin
		for (int j = 0; j < QW; j++) begin
			shf[j] = WE'(den_s[j]) << (QW - 1 - j);
			fit[j] = WE'(rem_s[j]) >= shf[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			sat_s[0] <= WE'(num) >= (WE'(den) << QW);
			tag_s[0] <= in_tag;
			for (int j = 1; j < QW; j++) begin
				rem_s[j] <= fit[j-1] ? rem_s[j-1] - shf[j-1][WN-1:0] : rem_s[j-1];
				den_s[j] <= den_s[j-1];
			end
			for (int j = 1; j < NS; j++) begin
				quo_s[j] <= {quo_s[j-1][QW-2:0], fit[j-1]};
				sat_s[j] <= sat_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
		end
	end

	assign out_vld = vld_s[NS-1];
	assign quo     = sat_s[NS-1] ? '1 : quo_s[NS-1];
	assign out_tag = tag_s[NS-1];

endmodule

// ===== src/pha_ang.sv =====
// Angle decision: ratio against the tangent step table, then count and sign.
// Depends on pha_pkg; its last register is the result register of the unit.
module pha_ang (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [pha_pkg::TAN_W-1:0] quo,
	input  pha_pkg::pha_flags_t       flags,
	output logic                      out_vld,
	output logic [pha_pkg::ANG_W-1:0] heading,
	output logic                      no_target
);
	import pha_pkg::*;

	logic [NUM_STEPS-1:0]    ge_c;
	logic [NUM_STEPS-1:0]    ge_s1;
	pha_flags_t              flg_s1;
	logic                    vld_s1;
	logic [CNT_W-1:0]        cnt_c;
	logic signed [ANG_W-1:0] mag_c;
	logic signed [ANG_W-1:0] hdg_c;
	logic                    vld_s2;

	for (genvar gk = 1; gk <= NUM_STEPS; gk++) begin : g_tan
		localparam logic [TAN_W-1:0] TK = tan_q32(gk);
		assign ge_c[gk-1] = quo >= TK;
	end

	always_comb begin
		cnt_c = CNT_W'($countones(ge_s1));
		mag_c = flg_s1.sat90 ? HDG_MAX : ANG_W'(cnt_c);
		if (flg_s1.no_tgt || flg_s1.q_zero) begin
			hdg_c = '0;
		end else begin
			hdg_c = flg_s1.neg ? -mag_c : mag_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ge_s1     <= ge_c;
			flg_s1    <= flags;
			heading   <= hdg_c;
			no_target <= flg_s1.no_tgt;
		end
	end

	assign out_vld = vld_s2;

endmodule

// ===== src/pixel_to_heading_angle_unit.sv =====
// Stages at PIXEL_BITS = 12: 4 front stages, 3 term multiply, 3 sum, 8 distance
// multiply, 39 divide, 2 angle; one request per cycle unless the output stalls.
// The whole pipeline advances whenever the result register is empty or taken.
// arst_n clears all valid bits and loads register defaults (offset 1.0, others 0).
// Top level; uses pha_pkg, pha_mul, pha_div, pha_ang.
module pixel_to_heading_angle_unit #(
	parameter int PIXEL_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// x_pixel, y_pixel, frame_width, frame_height from bit 0 up
	input  logic [((4*(PIXEL_BITS+1)+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// heading_deg
	output logic [pha_pkg::ANG_W-1:0] m_tdata,
	// no_target
	output logic m_tuser,
	input  logic cfg_we,
	input  logic [pha_pkg::IDX_W-1:0] cfg_idx,
	input  logic [pha_pkg::CFG_W-1:0] cfg_data
);
	import pha_pkg::*;

	localparam int FB  = PIXEL_BITS + 1;
	localparam int RW  = FB + 2;
	localparam int RM  = FB + 1;
	localparam int QSW = FB + 1;
	localparam int QM  = FB;
	localparam int SRW = CFG_W + RW;
	localparam int DW  = ((SRW > CFG_W + OFF_SHIFT) ? SRW : CFG_W + OFF_SHIFT) + 1;
	localparam int T3W = CFG_W + 3 * RM;
	localparam int T2W = CFG_W + 2 * RM + COEF_STEP;
	localparam int T1W = CFG_W + RM + 2 * COEF_STEP;
	localparam int T0W = CFG_W + 3 * COEF_STEP;
	localparam int M32 = (T3W > T2W) ? T3W : T2W;
	localparam int M10 = (T1W > T0W) ? T1W : T0W;
	localparam int SW  = ((M32 > M10) ? M32 : M10) + 3;
	localparam int FW  = SW - 1;
	localparam int PW  = CFG_W + 3 * RM;
	localparam int BW  = FW + DW;
	localparam int NW  = QM + LHS_SHIFT;
	localparam int FLW = $bits(pha_flags_t);

	logic en;

	logic signed [CFG_W-1:0] y_coef_cubic_q, y_coef_square_q, y_coef_linear_q;
	logic signed [CFG_W-1:0] y_coef_const_q, x_ratio_slope_q, x_ratio_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_coef_cubic_q   <= '0;
			y_coef_square_q  <= '0;
			y_coef_linear_q  <= '0;
			y_coef_const_q   <= '0;
			x_ratio_slope_q  <= '0;
			x_ratio_offset_q <= X_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_Y_CUBIC:  y_coef_cubic_q   <= cfg_data;
				REG_Y_SQUARE: y_coef_square_q  <= cfg_data;
				REG_Y_LINEAR: y_coef_linear_q  <= cfg_data;
				REG_Y_CONST:  y_coef_const_q   <= cfg_data;
				REG_X_SLOPE:  x_ratio_slope_q  <= cfg_data;
				REG_X_OFFSET: x_ratio_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// front end: r, q, powers of |r|, divisor
	logic signed [FB-1:0]  x_c, y_c;
	logic [FB-1:0]         w_c, h_c;
	logic signed [RW-1:0]  r_c;
	logic signed [QSW-1:0] q_c;

	assign x_c = s_tdata[FB-1:0];
	assign y_c = s_tdata[2*FB-1:FB];
	assign w_c = s_tdata[3*FB-1:2*FB];
	assign h_c = s_tdata[4*FB-1:3*FB];
	assign r_c = $signed({2'b00, h_c}) - $signed({{2{y_c[FB-1]}}, y_c});
	assign q_c = $signed({x_c[FB-1], x_c}) - $signed({2'b00, w_c[FB-1:1]});

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [RW-1:0]  r_s1;
	logic signed [QSW-1:0] q_s1, q_s2, q_s3, q_s4;
	logic                  nt_s1, nt_s2, nt_s3, nt_s4;
	logic [RM-1:0]         rm_s2, rm_s3, rm_s4;
	logic                  rneg_s2, rneg_s3, rneg_s4;
	logic signed [SRW-1:0] sr_s2;
	logic [2*RM-1:0]       r2_s3, r2_s4;
	logic signed [DW-1:0]  d_s3, d_s4;
	logic [3*RM-1:0]       r3_s4;
	logic [RW-1:0]         rabs_c;

	assign rabs_c = r_s1[RW-1] ? -r_s1 : r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= r_c;
			q_s1    <= q_c;
			nt_s1   <= x_c == '1;
			rm_s2   <= rabs_c[RM-1:0];
			rneg_s2 <= r_s1[RW-1];
			sr_s2   <= SRW'(x_ratio_slope_q) * SRW'(r_s1);
			q_s2    <= q_s1;
			nt_s2   <= nt_s1;
			r2_s3   <= (2*RM)'(rm_s2) * (2*RM)'(rm_s2);
			rm_s3   <= rm_s2;
			rneg_s3 <= rneg_s2;
			d_s3    <= DW'(sr_s2) + (DW'(x_ratio_offset_q) <<< OFF_SHIFT);
			q_s3    <= q_s2;
			nt_s3   <= nt_s2;
			r3_s4   <= (3*RM)'(r2_s3) * (3*RM)'(rm_s3);
			r2_s4   <= r2_s3;
			rm_s4   <= rm_s3;
			rneg_s4 <= rneg_s3;
			d_s4    <= d_s3;
			q_s4    <= q_s3;
			nt_s4   <= nt_s3;
		end
	end

	// polynomial terms as magnitude times slice-serial power of |r|
	logic [CFG_W-1:0] cm3_c, cm2_c, cm1_c;
	logic [2:0]       tsg_c, tsg_m;
	logic [PW-1:0]    t3_m, t2_m, t1_m;
	logic [QSW:0]     qt_m;
	logic [DW-1:0]    dt_m;
	logic             v3_m, v2_m, v1_m;

	assign cm3_c = y_coef_cubic_q[CFG_W-1]  ? -y_coef_cubic_q  : y_coef_cubic_q;
	assign cm2_c = y_coef_square_q[CFG_W-1] ? -y_coef_square_q : y_coef_square_q;
	assign cm1_c = y_coef_linear_q[CFG_W-1] ? -y_coef_linear_q : y_coef_linear_q;
	assign tsg_c = {y_coef_cubic_q[CFG_W-1] ^ rneg_s4, y_coef_square_q[CFG_W-1],
		y_coef_linear_q[CFG_W-1] ^ rneg_s4};

	pha_mul #(.WA(CFG_W), .WB(3*RM), .CW(RM), .TW(3)) u_mul_t3 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.a(cm3_c), .b(r3_s4), .in_tag(tsg_c),
		.out_vld(v3_m), .prod(t3_m), .out_tag(tsg_m)
	);

	pha_mul #(.WA(CFG_W), .WB(3*RM), .CW(RM), .TW(QSW+1)) u_mul_t2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.a(cm2_c), .b((3*RM)'(r2_s4)), .in_tag({nt_s4, q_s4}),
		.out_vld(v2_m), .prod(t2_m), .out_tag(qt_m)
	);

	pha_mul #(.WA(CFG_W), .WB(3*RM), .CW(RM), .TW(DW)) u_mul_t1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s4),
		.a(cm1_c), .b((3*RM)'(rm_s4)), .in_tag(d_s4),
		.out_vld(v1_m), .prod(t1_m), .out_tag(dt_m)
	);

	// signed sum of the aligned terms, then magnitudes and special cases
	logic signed [SW-1:0]  st3_c, st2_c, st1_c, st0_c;
	logic                  vld_s8, vld_s9, vld_s10;
	logic signed [SW-1:0]  hi_s8, lo_s8, sum_s9;
	logic signed [DW-1:0]  d_s8, d_s9;
	logic signed [QSW-1:0] q_s8, q_s9;
	logic                  nt_s8, nt_s9;
	logic [SW-1:0]         fabs_c;
	logic [DW-1:0]         dabs_c;
	logic [QSW-1:0]        qabs_c;
	logic [FW-1:0]         fm_s10;
	logic [DW-1:0]         dm_s10;
	logic [QM-1:0]         qm_s10;
	pha_flags_t            flg_s10;

	assign st3_c = tsg_m[2] ? -$signed(SW'(t3_m)) : $signed(SW'(t3_m));
	assign st2_c = tsg_m[1] ? -$signed(SW'(t2_m)) : $signed(SW'(t2_m));
	assign st1_c = tsg_m[0] ? -$signed(SW'(t1_m)) : $signed(SW'(t1_m));
	assign st0_c = SW'(y_coef_const_q);

	assign fabs_c = sum_s9[SW-1] ? -sum_s9 : sum_s9;
	assign dabs_c = d_s9[DW-1] ? -d_s9 : d_s9;
	assign qabs_c = q_s9[QSW-1] ? -q_s9 : q_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s8  <= v3_m && v2_m && v1_m;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s8          <= st3_c + (st2_c <<< COEF_STEP);
			lo_s8          <= (st1_c <<< (2*COEF_STEP)) + (st0_c <<< (3*COEF_STEP));
			d_s8           <= dt_m;
			q_s8           <= qt_m[QSW-1:0];
			nt_s8          <= qt_m[QSW];
			sum_s9         <= hi_s8 + lo_s8;
			d_s9           <= d_s8;
			q_s9           <= q_s8;
			nt_s9          <= nt_s8;
			fm_s10         <= fabs_c[FW-1:0];
			dm_s10         <= dabs_c;
			qm_s10         <= qabs_c[QM-1:0];
			flg_s10.no_tgt <= nt_s9;
			flg_s10.q_zero <= q_s9 == '0;
			flg_s10.sat90  <= (d_s9 == '0) || (sum_s9 == '0);
			flg_s10.neg    <= q_s9[QSW-1] ^ d_s9[DW-1];
		end
	end

	// divisor F * |D|, then |q| * 2^112 / (F * |D|)
	logic          vld_p;
	logic [BW-1:0] prod_p;
	logic [QM+FLW-1:0] tag_p;
	logic          vld_q;
	logic [TAN_W-1:0] quo_q;
	logic [FLW-1:0]   ftag_q;

	pha_mul #(.WA(FW), .WB(DW), .CW(MUL_CHUNK), .TW(QM+FLW)) u_mul_fd (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_s10),
		.a(fm_s10), .b(dm_s10), .in_tag({qm_s10, flg_s10}),
		.out_vld(vld_p), .prod(prod_p), .out_tag(tag_p)
	);

	pha_div #(.WN(NW), .WD(BW), .QW(TAN_W), .TW(FLW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_p),
		.num({tag_p[QM+FLW-1:FLW], {LHS_SHIFT{1'b0}}}), .den(prod_p),
		.in_tag(tag_p[FLW-1:0]),
		.out_vld(vld_q), .quo(quo_q), .out_tag(ftag_q)
	);

	pha_ang u_ang (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(vld_q),
		.quo(quo_q), .flags(pha_flags_t'(ftag_q)),
		.out_vld(m_tvalid), .heading(m_tdata), .no_target(m_tuser)
	);

`ifndef SYNTHESIS
	a_nt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("no-target result with nonzero heading");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= HDG_MAX) && ($signed(m_tdata) >= -HDG_MAX))
		else $error("heading out of range");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while pipeline stalled");
`endif

endmodule
